FILE: hdl/mpc_pkg.sv
// shared types and constants for the motor pwm command channel
// no dependencies; imported by mpc_div100 and motor_pwm_command_channel
package mpc_pkg;

  localparam int unsigned CHANNELS_DEF      = 5;
  localparam int unsigned FRACTION_BITS_DEF = 10;

  localparam int unsigned CH_W   = 3;   // channel field width
  localparam int unsigned CMD_W  = 18;  // signed command width
  localparam int unsigned MAG_W  = 17;  // stored magnitude width
  localparam int unsigned CMP_W  = 16;  // compare register width
  localparam int unsigned DB_W   = 10;  // deadband width
  localparam int unsigned PCT_W  = 7;   // integer percent width
  localparam int unsigned PRD_W  = PCT_W + CMP_W;  // off percent times period

  localparam int unsigned LOW_PCT  = 5;
  localparam int unsigned HIGH_PCT = 95;
  localparam int unsigned FULL_PCT = 100;

  // floor(2^23 / 100): quotient comes out exact or one low
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(83886);

  localparam logic [CMP_W-1:0] PERIOD_RST     = CMP_W'(16000);
  localparam logic [CMP_W-1:0] LOW_CLAMP_RST  = CMP_W'(47);
  localparam logic [CMP_W-1:0] HIGH_CLAMP_RST = CMP_W'(2);
  localparam logic [DB_W-1:0]  DEADBAND_RST   = DB_W'(10);

  typedef enum logic [1:0] {
    REG_PERIOD,
    REG_LOW_CLAMP,
    REG_HIGH_CLAMP,
    REG_DEADBAND
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_PERIOD,
    SEL_LOW,
    SEL_HIGH,
    SEL_MID
  } duty_sel_t;

  typedef struct packed {
    logic             en;
    logic [MAG_W-1:0] mag;
  } chan_state_t;

endpackage

FILE: hdl/motor_pwm_command_channel.sv
// motor pwm command channel top level: per-channel state ram, duty pipeline
// depends on mpc_pkg and mpc_div100
//
//   port group  handshake            contents
//   in_         in_valid/in_ready    channel, enable request, signed command
//   out_        out_valid/out_ready  channel, write strobe, compare a/b, driver enable
//   cfg_        cfg_we               register index and write data
//
// one word per cycle in, one word per cycle out while out_ready holds; a word
// passes the state ram read at acceptance, then modify/write, reciprocal
// multiply and correction before out_valid. a same-channel word right behind
// another is forwarded past the ram.
// reset clears per-channel valid bits at once, so no clearing pass is needed.
// stalls on out_ready back up stage by stage; empty stages still take words.
module motor_pwm_command_channel #(
  parameter int unsigned CHANNELS      = mpc_pkg::CHANNELS_DEF,
  parameter int unsigned FRACTION_BITS = mpc_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mpc_pkg::CH_W-1:0]           in_channel,
  input  logic                               in_enable_request,
  input  logic signed [mpc_pkg::CMD_W-1:0]   in_command,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mpc_pkg::CH_W-1:0]           out_channel,
  output logic                               out_write_strobe,
  output logic [mpc_pkg::CMP_W-1:0]          out_compare_a_value,
  output logic [mpc_pkg::CMP_W-1:0]          out_compare_b_value,
  output logic                               out_driver_enable,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [mpc_pkg::CMP_W-1:0]          cfg_wdata
);
  import mpc_pkg::*;

  localparam int unsigned AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LOW_MAG  = LOW_PCT << FRACTION_BITS;
  localparam int unsigned HIGH_MAG = HIGH_PCT << FRACTION_BITS;

  // configuration registers
  logic [CMP_W-1:0] period_r, low_cmp_r, high_cmp_r;
  logic [DB_W-1:0]  deadband_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= PERIOD_RST;
      low_cmp_r  <= LOW_CLAMP_RST;
      high_cmp_r <= HIGH_CLAMP_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PERIOD:     period_r   <= cfg_wdata;
        REG_LOW_CLAMP:  low_cmp_r  <= cfg_wdata;
        REG_HIGH_CLAMP: high_cmp_r <= cfg_wdata;
        REG_DEADBAND:   deadband_r <= cfg_wdata[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance chain
  logic out_valid_r, s1_vld_r, s2_vld_r, s3_vld_r;
  logic out_adv, s3_adv, s2_adv, s1_adv;

  assign out_adv  = !out_valid_r || out_ready;
  assign s3_adv   = !s3_vld_r || out_adv;
  assign s2_adv   = !s2_vld_r || s3_adv;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  logic          in_ok;
  logic [AW-1:0] in_addr;

  assign in_ok   = (32'(in_channel) < CHANNELS);
  assign in_addr = AW'(in_channel);

  // state ram with per-entry valid bits
  chan_state_t           mem [CHANNELS];
  logic [CHANNELS-1:0]   ent_vld_r;
  chan_state_t           rd_r, fwd_r, wr_state;
  logic                  rd_vld_r, fwd_hit_r, mem_wr;

  // stage 1 registers
  logic                  s1_ok_r, s1_en_r;
  logic [CH_W-1:0]       s1_ch_r;
  logic [AW-1:0]         s1_addr_r;
  logic signed [CMD_W-1:0] s1_cmd_r;

  assign mem_wr = s1_vld_r && s1_ok_r && s2_adv;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[s1_addr_r] <= wr_state;
    end
    if (s1_adv && in_valid && in_ok) begin
      rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (mem_wr) begin
      ent_vld_r[s1_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ok_r   <= in_ok;
      s1_en_r   <= in_enable_request;
      s1_ch_r   <= in_channel;
      s1_addr_r <= in_addr;
      s1_cmd_r  <= in_command;
      // the word leaving stage 1 writes the entry this word just read
      fwd_hit_r <= mem_wr && (s1_addr_r == in_addr);
      fwd_r     <= wr_state;
      if (in_valid && in_ok) begin
        rd_vld_r <= ent_vld_r[in_addr];
      end
    end
  end

  // stage 1 read-modify-write
  chan_state_t      cur;
  logic [CMD_W-1:0] neg_cmd;
  logic [MAG_W-1:0] mag, diff;
  logic [PCT_W-1:0] off_pct;
  logic             drive, s1_strobe, s1_drv;
  duty_sel_t        s1_sel;
  logic [PRD_W-1:0] s1_x;

  always_comb begin
    cur = fwd_hit_r ? fwd_r : (rd_vld_r ? rd_r : '0);
    neg_cmd = ~s1_cmd_r + 1'b1;
    if (s1_cmd_r[CMD_W-1]) begin
      // most negative command saturates
      mag = (s1_cmd_r[CMD_W-2:0] == '0) ? '1 : neg_cmd[MAG_W-1:0];
    end else begin
      mag = s1_cmd_r[MAG_W-1:0];
    end
    diff  = (mag >= cur.mag) ? mag - cur.mag : cur.mag - mag;
    drive = s1_en_r && cur.en;
    wr_state.en  = s1_en_r;
    wr_state.mag = drive ? mag : '0;
    s1_drv    = s1_ok_r && (s1_en_r || cur.en);
    if (!s1_ok_r) begin
      s1_strobe = 1'b0;
    end else if (drive) begin
      s1_strobe = diff > MAG_W'(deadband_r);
    end else begin
      s1_strobe = 1'b1;
    end
    if (!drive) begin
      s1_sel = SEL_PERIOD;
    end else if (32'(mag) <= LOW_MAG) begin
      s1_sel = SEL_LOW;
    end else if (32'(mag) >= HIGH_MAG) begin
      s1_sel = SEL_HIGH;
    end else begin
      s1_sel = SEL_MID;
    end
    off_pct = PCT_W'(FULL_PCT) - PCT_W'(mag >> FRACTION_BITS);
    s1_x    = PRD_W'(off_pct) * PRD_W'(period_r);
  end

  // stage 2 registers
  logic             s2_strobe_r, s2_drv_r;
  logic [CH_W-1:0]  s2_ch_r;
  duty_sel_t        s2_sel_r;
  logic [PRD_W-1:0] s2_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_strobe_r <= s1_strobe;
      s2_drv_r    <= s1_drv;
      s2_ch_r     <= s1_ch_r;
      s2_sel_r    <= s1_sel;
      s2_x_r      <= s1_x;
    end
  end

  // stage 3: divide by 100 runs alongside
  logic             s3_strobe_r, s3_drv_r;
  logic [CH_W-1:0]  s3_ch_r;
  duty_sel_t        s3_sel_r;
  logic [CMP_W-1:0] duty_q;

  mpc_div100 u_div (
    .clk (clk),
    .en  (s3_adv),
    .x_i (s2_x_r),
    .q_o (duty_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_strobe_r <= s2_strobe_r;
      s3_drv_r    <= s2_drv_r;
      s3_ch_r     <= s2_ch_r;
      s3_sel_r    <= s2_sel_r;
    end
  end

  // output register
  logic             out_strobe_r, out_drv_r;
  logic [CH_W-1:0]  out_ch_r;
  logic [CMP_W-1:0] out_ca_r, out_cb_r;
  logic [CMP_W-1:0] cb_nxt;

  always_comb begin
    cb_nxt = '0;
    if (s3_strobe_r) begin
      case (s3_sel_r)
        SEL_PERIOD: cb_nxt = period_r;
        SEL_LOW:    cb_nxt = low_cmp_r;
        SEL_HIGH:   cb_nxt = high_cmp_r;
        default:    cb_nxt = duty_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_strobe_r <= s3_strobe_r;
      out_drv_r    <= s3_drv_r;
      out_ch_r     <= s3_ch_r;
      out_ca_r     <= s3_strobe_r ? period_r : '0;
      out_cb_r     <= cb_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel         = out_ch_r;
  assign out_write_strobe    = out_strobe_r;
  assign out_compare_a_value = out_ca_r;
  assign out_compare_b_value = out_cb_r;
  assign out_driver_enable   = out_drv_r;

endmodule

FILE: hdl/mpc_div100.sv
// divide by 100 of the off-time product, by registered reciprocal multiply
// and one remainder correction; depends on mpc_pkg
module mpc_div100 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mpc_pkg::PRD_W-1:0]   x_i,
  output logic [mpc_pkg::CMP_W-1:0]   q_o
);
  import mpc_pkg::*;

  logic [PRD_W+RECIP_W-1:0] prod_r;
  logic [PRD_W-1:0]         x_r;
  logic [CMP_W-1:0]         q_est;
  logic [PRD_W-1:0]         rem;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (PRD_W+RECIP_W)'(x_i) * (PRD_W+RECIP_W)'(RECIP);
      x_r    <= x_i;
    end
  end

  always_comb begin
    q_est = prod_r[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
    rem   = x_r - PRD_W'(q_est) * PRD_W'(FULL_PCT);
    // estimate is at most one low
    q_o   = (rem >= PRD_W'(FULL_PCT)) ? q_est + 1'b1 : q_est;
  end

endmodule

FILE: dv/motor_pwm_command_channel_test.sv
// self-checking testbench for motor_pwm_command_channel: random and directed control ticks,
// per-channel predictor in a small scoreboard class, random idling on both handshakes
// depends on mpc_pkg and the motor_pwm_command_channel rtl
module motor_pwm_command_channel_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpc_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             strobe;
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    logic             drv;
  } pwm_word_t;

  class pwm_scoreboard;
    logic [CMP_W-1:0] period;
    logic [CMP_W-1:0] low_clamp;
    logic [CMP_W-1:0] high_clamp;
    logic [DB_W-1:0]  deadband;
    logic             en_hist [CHANNELS_DEF];
    logic [MAG_W-1:0] mag_hist [CHANNELS_DEF];
    pwm_word_t        expected_q [$];
    int unsigned      errors;

    function new();
      period     = PERIOD_RST;
      low_clamp  = LOW_CLAMP_RST;
      high_clamp = HIGH_CLAMP_RST;
      deadband   = DEADBAND_RST;
      errors     = 0;
      foreach (en_hist[i]) begin
        en_hist[i]  = 1'b0;
        mag_hist[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_t r, logic [CMP_W-1:0] v);
      case (r)
        REG_PERIOD:     period = v;
        REG_LOW_CLAMP:  low_clamp = v;
        REG_HIGH_CLAMP: high_clamp = v;
        REG_DEADBAND:   deadband = v[DB_W-1:0];
        default: ;
      endcase
    endfunction

    // |command|, with the most negative command saturating to the 17-bit max
    function logic [MAG_W-1:0] command_magnitude(logic signed [CMD_W-1:0] cmd);
      logic [CMD_W:0] m;
      if (cmd[CMD_W-1]) m = ((CMD_W+1)'(1) << CMD_W) - {1'b0, cmd};
      else m = {1'b0, cmd};
      if (m[CMD_W:MAG_W] != '0) return '1;
      return m[MAG_W-1:0];
    endfunction

    function logic [CMP_W-1:0] off_time_compare(logic [MAG_W-1:0] mag);
      int unsigned pct;
      if (mag <= (LOW_PCT << FRACTION_BITS_DEF)) return low_clamp;
      if (mag >= (HIGH_PCT << FRACTION_BITS_DEF)) return high_clamp;
      pct = mag >> FRACTION_BITS_DEF;
      return CMP_W'(((FULL_PCT - pct) * int'(period)) / FULL_PCT);
    endfunction

    function void note_word(logic [CH_W-1:0] ch, logic en, logic signed [CMD_W-1:0] cmd);
      pwm_word_t        w;
      logic [MAG_W-1:0] mag;
      logic [MAG_W-1:0] diff;
      logic             was_on;
      w = '0;
      w.ch = ch;
      if (ch < CHANNELS_DEF) begin
        was_on = en_hist[ch];
        w.drv = en | was_on;
        en_hist[ch] = en;
        if (en && was_on) begin
          mag = command_magnitude(cmd);
          diff = (mag >= mag_hist[ch]) ? mag - mag_hist[ch] : mag_hist[ch] - mag;
          mag_hist[ch] = mag;
          if (diff > deadband) begin
            w.strobe = 1'b1;
            w.cmp_a  = period;
            w.cmp_b  = off_time_compare(mag);
          end
        end else begin
          // not yet enabled for two ticks: zero duty, magnitude forgotten
          mag_hist[ch] = '0;
          w.strobe = 1'b1;
          w.cmp_a  = period;
          w.cmp_b  = period;
        end
      end
      expected_q.push_back(w);
    endfunction

    task report(string field, int unsigned got, int unsigned want);
      $display("%0t ns: mismatch on %s, got %0d expected %0d", $time, field, got, want);
      errors++;
    endtask

    task check_word(pwm_word_t got);
      pwm_word_t want;
      if (expected_q.size() == 0) begin
        report("word with nothing expected, channel", got.ch, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.ch !== want.ch) report("out_channel", got.ch, want.ch);
      if (got.strobe !== want.strobe) report("write_strobe", got.strobe, want.strobe);
      if (got.cmp_a !== want.cmp_a) report("compare_a_value", got.cmp_a, want.cmp_a);
      if (got.cmp_b !== want.cmp_b) report("compare_b_value", got.cmp_b, want.cmp_b);
      if (got.drv !== want.drv) report("driver_enable", got.drv, want.drv);
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CH_W-1:0]          in_channel;
  logic                     in_enable_request;
  logic signed [CMD_W-1:0]  in_command;
  logic                     out_valid;
  logic                     out_ready;
  logic [CH_W-1:0]          out_channel;
  logic                     out_write_strobe;
  logic [CMP_W-1:0]         out_compare_a_value;
  logic [CMP_W-1:0]         out_compare_b_value;
  logic                     out_driver_enable;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [CMP_W-1:0]         cfg_wdata;

  pwm_scoreboard            sb;
  bit                       idle_on;
  bit                       squeeze;
  logic signed [CMD_W-1:0]  last_cmd [CHANNELS_DEF];

  motor_pwm_command_channel dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_channel          (in_channel),
    .in_enable_request   (in_enable_request),
    .in_command          (in_command),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_channel         (out_channel),
    .out_write_strobe    (out_write_strobe),
    .out_compare_a_value (out_compare_a_value),
    .out_compare_b_value (out_compare_b_value),
    .out_driver_enable   (out_driver_enable),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("motor_pwm_command_channel test failed");
    $finish;
  end

  // offer one word and hold it until the block takes it
  task send_word(input logic [CH_W-1:0] ch, input logic en, input logic signed [CMD_W-1:0] cmd);
    in_valid          <= 1'b1;
    in_channel        <= ch;
    in_enable_request <= en;
    in_command        <= cmd;
    do @(posedge clk); while (!in_ready);
    sb.note_word(ch, en, cmd);
  endtask

  task pause_sender();
    while (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task write_reg(cfg_reg_t r, logic [CMP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  task set_config(logic [CMP_W-1:0] prd, logic [CMP_W-1:0] lo, logic [CMP_W-1:0] hi,
                  logic [CMP_W-1:0] db);
    write_reg(REG_PERIOD, prd);
    write_reg(REG_LOW_CLAMP, lo);
    write_reg(REG_HIGH_CLAMP, hi);
    write_reg(REG_DEADBAND, db);
    cfg_we <= 1'b0;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic signed [CMD_W-1:0] pick_command(logic [CH_W-1:0] ch);
    int unsigned             mode;
    int                      step;
    int                      db;
    int                      base;
    mode = $urandom_range(99);
    db = int'(sb.deadband);
    if (mode < 30 || ch >= CHANNELS_DEF) return CMD_W'($urandom);
    // small moves around the deadband edge
    if (mode < 60) begin
      step = int'($urandom_range(2 * db + 4)) - (db + 2);
      return last_cmd[ch] + CMD_W'(step);
    end
    // clamp thresholds, either sign
    if (mode < 80) begin
      base = ($urandom_range(1) ? LOW_PCT : HIGH_PCT) << FRACTION_BITS_DEF;
      base = base + int'($urandom_range(4)) - 2;
      return CMD_W'($urandom_range(1) ? -base : base);
    end
    return CMD_W'(int'($urandom_range(204800)) - 102400);
  endfunction

  task run_random(int unsigned n);
    logic [CH_W-1:0]         ch;
    logic                    en;
    logic signed [CMD_W-1:0] cmd;
    repeat (n) begin
      if ($urandom_range(99) < 5) ch = CH_W'($urandom_range(7, CHANNELS_DEF));
      else ch = CH_W'($urandom_range(CHANNELS_DEF - 1));
      en  = ($urandom_range(99) < 85);
      cmd = pick_command(ch);
      if (ch < CHANNELS_DEF) last_cmd[ch] = cmd;
      send_word(ch, en, cmd);
      pause_sender();
    end
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned hold;
    pwm_word_t   got;
    hold = 0;
    out_ready <= 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      if (squeeze) begin
        squeeze = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= !(idle_on && $urandom_range(99) < 37);
      end
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.ch     = out_channel;
        got.strobe = out_write_strobe;
        got.cmp_a  = out_compare_a_value;
        got.cmp_b  = out_compare_b_value;
        got.drv    = out_driver_enable;
        sb.check_word(got);
      end
    end
  end

  initial begin
    sb = new();
    idle_on = 1'b1;
    squeeze = 1'b0;
    foreach (last_cmd[i]) last_cmd[i] = '0;
    in_valid          <= 1'b0;
    in_channel        <= '0;
    in_enable_request <= 1'b0;
    in_command        <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PERIOD;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset settings
    send_word(0, 1, 0);           // first enabled tick still outputs zero duty
    send_word(0, 1, 131071);      // largest positive, high clamp
    send_word(0, 1, -131072);     // most negative saturates, no change
    send_word(0, 1, 5120);        // exactly 5 percent, low clamp
    pause_sender();
    send_word(0, 1, -5121);       // inside deadband
    send_word(0, 1, 5132);        // just past deadband, mid range
    send_word(0, 1, -97280);      // exactly 95 percent
    send_word(0, 1, 97279);
    send_word(0, 1, 97268);       // 94 percent
    pause_sender();
    send_word(0, 0, 0);           // enable drop still holds the driver one tick
    send_word(0, 0, 0);
    send_word(0, 1, 1000);
    send_word(1, 1, 20);
    send_word(1, 1, 20);
    send_word(1, 1, 30);          // change equal to deadband, no write
    send_word(1, 1, 41);
    pause_sender();
    send_word(2, 1, 0);
    send_word(3, 0, 1);
    send_word(4, 1, -1);
    send_word(5, 1, 1234);        // channels past the last one are ignored
    send_word(6, 0, 0);
    send_word(7, 1, -131072);
    drain();

    set_config(16000, 47, 2, 10);
    run_random(170);
    drain();

    set_config(16'hFFFF, 16'hFFFF, 0, 0);
    squeeze = 1'b1;
    run_random(170);
    drain();

    set_config(1, 0, 16'hFFFF, 1023);
    idle_on = 1'b0;
    run_random(170);
    idle_on = 1'b1;
    drain();

    // zero period; deadband write carries junk above its 10 bits
    set_config(0, 12345, 54321, 16'hFFFF);
    run_random(170);
    drain();

    repeat (2) begin
      set_config(CMP_W'($urandom), CMP_W'($urandom), CMP_W'($urandom),
                 CMP_W'($urandom_range(64)));
      run_random(170);
      drain();
    end

    if (sb.errors == 0) begin
      $display("motor_pwm_command_channel test passed");
    end else begin
      $display("motor_pwm_command_channel test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mpc_pkg.sv
hdl/mpc_div100.sv
hdl/motor_pwm_command_channel.sv
dv/motor_pwm_command_channel_test.sv
